// File: src/rcrc_pkg.sv
// Shared types and constants for the reflected CRC-32 engine.
package rcrc_pkg;

    localparam int unsigned CRC_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [CRC_W-1:0] POLY_RESET  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] START_RESET = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_XOROUT  = 32'hFFFF_FFFF;

    // Register word index, taken from paddr[2]
    typedef enum logic
    {
        REG_POLYNOMIAL  = 1'b0,
        REG_START_VALUE = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] start_value;
    } cfg_t;

endpackage

// File: src/rcrc_stream_if.sv
// Valid/ready channel interfaces for message bytes and CRC results.
interface rcrc_byte_if;
    logic                             valid;
    logic                             ready;
    logic [rcrc_pkg::BYTE_W-1:0]      data_byte;
    logic                             has_byte;
    logic                             first;
    logic                             last;

    modport source (output valid, output data_byte, output has_byte, output first,
                    output last, input ready);
    modport sink   (input valid, input data_byte, input has_byte, input first,
                    input last, output ready);
endinterface

interface rcrc_crc_if;
    logic                             valid;
    logic                             ready;
    logic [rcrc_pkg::CRC_W-1:0]       crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

// File: src/reflected_crc32_engine_core.sv
// Top level of the reflected CRC-32 engine: APB registers and byte pipeline.
// Result path: a beat with last goes through the input register, then the result register.
// Throughput: one byte beat per cycle; the eight shift/XOR steps sit in one register to
//   register path. A held beat with last stalls input only while a result waits unread.
// Reset (rst_n low, async): polynomial 0xEDB88320, start value and remainder all ones.
module reflected_crc32_engine_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rcrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rcrc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    rcrc_byte_if.sink                      din,
    rcrc_crc_if.source                     dout
);

    // Current configuration; the user must write it only while the pipeline is idle (the block
    // does not enforce this), so the datapath reads it directly without a shadow copy.
    rcrc_pkg::cfg_t cfg;

    // Register map: word 0 polynomial, word 1 start value (paddr[2] selects).
    rcrc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Byte beats flow through the input register; the remainder updates when
    // a beat retires, and a beat with last loads the result register with the
    // final value XOR all ones. The input side keeps accepting while a result
    // waits, unless the held beat itself needs the result slot.
    rcrc_pipe u_pipe
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .din   (din),
        .dout  (dout)
    );

endmodule

// File: src/rcrc_cfg_regs.sv
// APB register file holding the polynomial and start value.
module rcrc_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rcrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rcrc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output rcrc_pkg::cfg_t                 cfg
);

    rcrc_pkg::cfg_t     cfg_reg;
    rcrc_pkg::cfg_t     cfg_next;
    rcrc_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = rcrc_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                rcrc_pkg::REG_POLYNOMIAL:  cfg_next.polynomial  = pwdata;
                rcrc_pkg::REG_START_VALUE: cfg_next.start_value = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rcrc_pkg::REG_POLYNOMIAL:  prdata = cfg_reg.polynomial;
            rcrc_pkg::REG_START_VALUE: prdata = cfg_reg.start_value;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.polynomial  <= rcrc_pkg::POLY_RESET;
            cfg_reg.start_value <= rcrc_pkg::START_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/rcrc_absorb.sv
// Eight reflected shift/XOR steps absorbing one byte into the remainder.
module rcrc_absorb
(
    input  logic [rcrc_pkg::CRC_W-1:0]  rem_in,
    input  logic [rcrc_pkg::BYTE_W-1:0] data_byte,
    input  logic                        has_byte,
    input  logic [rcrc_pkg::CRC_W-1:0]  polynomial,
    output logic [rcrc_pkg::CRC_W-1:0]  rem_out
);

    always_comb
    begin
        logic [rcrc_pkg::CRC_W-1:0] r;
        r = rem_in ^ {{(rcrc_pkg::CRC_W-rcrc_pkg::BYTE_W){1'b0}}, data_byte};
        for (int k = 0; k < rcrc_pkg::BYTE_W; k++)
        begin
            r = {1'b0, r[rcrc_pkg::CRC_W-1:1]} ^ (polynomial & {rcrc_pkg::CRC_W{r[0]}});
        end
        rem_out = has_byte ? r : rem_in;
    end

endmodule

// File: src/rcrc_pipe.sv
// Input beat register, running remainder and result register.
module rcrc_pipe
(
    input  logic             clk,
    input  logic             rst_n,
    input  rcrc_pkg::cfg_t   cfg,
    rcrc_byte_if.sink        din,
    rcrc_crc_if.source       dout
);

    // Input stage
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [rcrc_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                        s1_has_reg;
    logic                        s1_first_reg;
    logic                        s1_last_reg;

    // Running remainder
    logic [rcrc_pkg::CRC_W-1:0]  rem_reg;
    logic [rcrc_pkg::CRC_W-1:0]  rem_base;
    logic [rcrc_pkg::CRC_W-1:0]  rem_new;

    // Result stage
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rcrc_pkg::CRC_W-1:0]  crc_reg;

    logic                        in_fire;
    logic                        out_free;
    logic                        s1_adv;

    assign out_free = !out_valid_reg || dout.ready;
    // a beat without last never needs the result slot
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign din.ready = !s1_valid_reg || s1_adv;
    assign in_fire  = din.valid && din.ready;

    assign rem_base = s1_first_reg ? cfg.start_value : rem_reg;

    rcrc_absorb u_absorb
    (
        .rem_in     (rem_base),
        .data_byte  (s1_byte_reg),
        .has_byte   (s1_has_reg),
        .polynomial (cfg.polynomial),
        .rem_out    (rem_new)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= rcrc_pkg::START_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                rem_reg <= rem_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg  <= din.data_byte;
            s1_has_reg   <= din.has_byte;
            s1_first_reg <= din.first;
            s1_last_reg  <= din.last;
        end
        if (s1_adv && s1_last_reg)
        begin
            crc_reg <= rem_new ^ rcrc_pkg::CRC_XOROUT;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.crc_value = crc_reg;

`ifndef SYNTHESIS
    a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> out_valid_reg)
        else $error("last beat retired without a result");

    a_rem_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(rem_reg))
        else $error("remainder changed without a retiring beat");

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stalled input beat lost");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> din.ready)
        else $error("empty input stage not ready");
`endif

endmodule

// File: test/tb_reflected_crc32_engine_core.sv
// Self-checking testbench for the reflected CRC-32 engine: APB setup, byte stream, CRC results.
`timescale 1ns / 1ps

module tb_reflected_crc32_engine_core;

    // Run sizing: directed table plus eight random phases of about 220 beats
    localparam int unsigned PHASES        = 8;
    localparam int unsigned RANDOM_BEATS  = 220;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned DRAIN_CYCLES  = 4;
    localparam int unsigned REPORT_MAX    = 10;

    // Throttling modes, one per phase in rotation
    typedef enum int unsigned
    {
        THROTTLE_NONE   = 0,
        THROTTLE_SENDER = 1,
        THROTTLE_RECV   = 2,
        THROTTLE_BOTH   = 3
    } throttle_t;

    typedef struct packed
    {
        logic [rcrc_pkg::BYTE_W-1:0] data_byte;
        logic                        has_byte;
        logic                        first;
        logic                        last;
    } crc_beat_t;

    // Directed row: a beat, plus a typed-in CRC where one is known by heart
    typedef struct packed
    {
        crc_beat_t                  beat;
        logic                       fixed;
        logic [rcrc_pkg::CRC_W-1:0] crc;
    } crc_row_t;

    localparam int unsigned DIRECTED_ROWS = 21;

    localparam crc_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // remainder out of reset is all ones, so no first flag is needed
        '{'{8'h00, 1'b1, 1'b0, 1'b1}, 1'b1, 32'hD202_EF8D},
        // empty message, with and without junk on the byte lane
        '{'{8'h00, 1'b0, 1'b1, 1'b1}, 1'b1, 32'h0000_0000},
        '{'{8'hFF, 1'b0, 1'b1, 1'b1}, 1'b1, 32'h0000_0000},
        // standard check string "123456789"
        '{'{8'h31, 1'b1, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'h32, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h33, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h34, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h35, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h36, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h37, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h38, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
        '{'{8'h39, 1'b1, 1'b0, 1'b1}, 1'b1, 32'hCBF4_3926},
        '{'{8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, 32'h0},
        // continue from the finished message without a reload
        '{'{8'h80, 1'b1, 1'b0, 1'b1}, 1'b0, 32'h0},
        // beat that carries nothing
        '{'{8'h5A, 1'b0, 1'b0, 1'b0}, 1'b0, 32'h0},
        // first without a byte, then the byte
        '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'hA5, 1'b1, 1'b0, 1'b1}, 1'b0, 32'h0},
        // second first flag in the middle of a message reloads
        '{'{8'h12, 1'b1, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'h34, 1'b1, 1'b1, 1'b1}, 1'b0, 32'h0},
        '{'{8'h7F, 1'b1, 1'b1, 1'b0}, 1'b0, 32'h0},
        '{'{8'h01, 1'b1, 1'b0, 1'b1}, 1'b0, 32'h0}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rcrc_pkg::PADDR_W-1:0]  paddr;
    logic [rcrc_pkg::PDATA_W-1:0]  pwdata;
    logic [rcrc_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    rcrc_byte_if din_bus ();
    rcrc_crc_if  dout_bus ();

    reflected_crc32_engine_core u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .din     (din_bus),
        .dout    (dout_bus)
    );

    // Predictor state: running remainder and the register copies
    logic [rcrc_pkg::CRC_W-1:0] crc_rem;
    logic [rcrc_pkg::CRC_W-1:0] cfg_poly;
    logic [rcrc_pkg::CRC_W-1:0] cfg_start;

    // CRC values still owed by the block, oldest first
    logic [rcrc_pkg::CRC_W-1:0] crc_expect_q [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned results_checked;
    int unsigned beats_sent;
    int unsigned bytes_sent;
    int unsigned settings_used;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One byte through eight LSB-first shift steps
    function automatic logic [rcrc_pkg::CRC_W-1:0] crc_shift_byte(
        logic [rcrc_pkg::CRC_W-1:0]  rem,
        logic [rcrc_pkg::BYTE_W-1:0] data,
        logic [rcrc_pkg::CRC_W-1:0]  poly);
        logic [rcrc_pkg::CRC_W-1:0] r;
        r = rem ^ {{(rcrc_pkg::CRC_W-rcrc_pkg::BYTE_W){1'b0}}, data};
        for (int k = 0; k < rcrc_pkg::BYTE_W; k++)
            r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [rcrc_pkg::CRC_W-1:0] want,
                                 input logic [rcrc_pkg::CRC_W-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] MISMATCH %s: expected %08h, got %08h", $time, what, want, got);
    endtask

    // Update the predictor for one accepted beat and queue its result, if any.
    // A fixed row overrides the predicted value with the typed-in one.
    task automatic track_beat(input crc_beat_t b, input logic fixed,
                              input logic [rcrc_pkg::CRC_W-1:0] fixed_crc);
        if (b.first)
            crc_rem = cfg_start;
        if (b.has_byte)
        begin
            crc_rem = crc_shift_byte(crc_rem, b.data_byte, cfg_poly);
            bytes_sent++;
        end
        if (b.last)
            crc_expect_q.push_back(fixed ? fixed_crc : (crc_rem ^ rcrc_pkg::CRC_XOROUT));
    endtask

    // Present one beat; returns once it has been accepted. Called right after an edge.
    task automatic send_beat(input crc_beat_t b, input logic fixed,
                             input logic [rcrc_pkg::CRC_W-1:0] fixed_crc);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            din_bus.valid <= 1'b0;
            @(posedge clk);
        end
        din_bus.valid     <= 1'b1;
        din_bus.data_byte <= b.data_byte;
        din_bus.has_byte  <= b.has_byte;
        din_bus.first     <= b.first;
        din_bus.last      <= b.last;
        @(posedge clk);
        while (!din_bus.ready)
            @(posedge clk);
        track_beat(b, fixed, fixed_crc);
        beats_sent++;
    endtask

    // APB write (setup + access) followed by a read-back of the same register
    task automatic write_register(input rcrc_pkg::reg_idx_t idx,
                                  input logic [rcrc_pkg::CRC_W-1:0] value);
        logic [rcrc_pkg::PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == rcrc_pkg::REG_POLYNOMIAL)
            cfg_poly = value;
        else
            cfg_start = value;

        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback != value)
            note_mismatch(idx == rcrc_pkg::REG_POLYNOMIAL ? "polynomial readback"
                                                          : "start readback",
                          value, readback);
    endtask

    // Random traffic: mostly well-formed messages with random bytes, the rest
    // empty messages and loosely framed beats.
    task automatic send_random_messages(input int unsigned target);
        int unsigned start_count;
        int unsigned shape;
        int unsigned len;
        crc_beat_t   b;
        start_count = beats_sent;
        while (beats_sent - start_count < target)
        begin
            shape = $urandom_range(0, 99);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                 : $urandom_range(1, 16);
            if (shape < 80)
            begin
                for (int k = 0; k < len; k++)
                begin
                    b.data_byte = 8'($urandom);
                    b.first     = (k == 0);
                    b.last      = (k == len - 1);
                    // occasional byte-less beat inside a message
                    b.has_byte  = ($urandom_range(0, 19) != 0);
                    send_beat(b, 1'b0, '0);
                end
            end
            else if (shape < 87)
            begin
                b.data_byte = 8'($urandom);
                b.has_byte  = 1'b0;
                b.first     = 1'b1;
                b.last      = 1'b1;
                send_beat(b, 1'b0, '0);
            end
            else
            begin
                // loose framing: flags at random, messages run together
                for (int k = 0; k < len; k++)
                begin
                    b.data_byte = 8'($urandom);
                    b.has_byte  = 1'($urandom);
                    b.first     = 1'($urandom);
                    b.last      = 1'($urandom);
                    send_beat(b, 1'b0, '0);
                end
            end
        end
        din_bus.valid <= 1'b0;
    endtask

    // Everything queued has come back, and the pipeline has flushed any
    // result-less beats behind it.
    task automatic wait_idle();
        while (crc_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check at the edge, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            if (crc_expect_q.size() == 0)
                note_mismatch("unexpected result", '0, dout_bus.crc_value);
            else
            begin
                logic [rcrc_pkg::CRC_W-1:0] want;
                want = crc_expect_q.pop_front();
                results_checked++;
                if (dout_bus.crc_value != want)
                    note_mismatch("crc_value", want, dout_bus.crc_value);
            end
        end
        dout_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, crc_expect_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [rcrc_pkg::CRC_W-1:0] poly_set;
        logic [rcrc_pkg::CRC_W-1:0] start_set;
        throttle_t                  mode;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        din_bus.valid     <= 1'b0;
        din_bus.data_byte <= '0;
        din_bus.has_byte  <= 1'b0;
        din_bus.first     <= 1'b0;
        din_bus.last      <= 1'b0;
        fail_count        = 0;
        results_checked   = 0;
        beats_sent        = 0;
        bytes_sent        = 0;
        settings_used     = 1;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;

        // predictor mirrors the reset state
        cfg_poly  = rcrc_pkg::POLY_RESET;
        cfg_start = rcrc_pkg::START_RESET;
        crc_rem   = rcrc_pkg::START_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // register settings: reset values first, then the corners, a random
            // pair, a second well-known polynomial, and back to the defaults
            if (phase > 0)
            begin
                case (phase)
                    1:
                    begin
                        poly_set = 32'h0000_0000; start_set = 32'h0000_0000;
                    end
                    2:
                    begin
                        poly_set = 32'hFFFF_FFFF; start_set = 32'hFFFF_FFFF;
                    end
                    3:
                    begin
                        poly_set = 32'hFFFF_FFFF; start_set = 32'h0000_0000;
                    end
                    4:
                    begin
                        poly_set = 32'h0000_0000; start_set = 32'hFFFF_FFFF;
                    end
                    5:
                    begin
                        poly_set = $urandom;      start_set = $urandom;
                    end
                    6:
                    begin
                        poly_set = 32'h82F6_3B78; start_set = rcrc_pkg::START_RESET;
                    end
                    default:
                    begin
                        poly_set = rcrc_pkg::POLY_RESET; start_set = rcrc_pkg::START_RESET;
                    end
                endcase
                write_register(rcrc_pkg::REG_POLYNOMIAL, poly_set);
                write_register(rcrc_pkg::REG_START_VALUE, start_set);
                settings_used++;
            end

            mode = throttle_t'(phase % 4);
            case (mode)
                THROTTLE_NONE:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                THROTTLE_SENDER: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                THROTTLE_RECV:   begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default:         begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase

            if (phase == 0)
            begin
                for (int r = 0; r < DIRECTED_ROWS; r++)
                    send_beat(DIRECTED[r].beat, DIRECTED[r].fixed, DIRECTED[r].crc);
            end

            send_random_messages(RANDOM_BEATS);
            wait_idle();
        end

        $display("Covered %0d beats (%0d bytes) over %0d register settings and 4 throttle modes",
                 beats_sent, bytes_sent, settings_used);
        $display("Checked %0d CRC results, %0d failures", results_checked, fail_count);
        if (fail_count == 0 && crc_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
